// ----- sv/swtb_pkg.sv -----
// Package with the types, codes and defaults shared by the stopwatch timer bank.
`default_nettype none
package swtb_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int CMD_W          = 3;
    localparam int INDEX_W        = 4;
    localparam int COUNT_W        = 32;
    localparam int STATUS_W       = 2;

    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PAUSE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        RUN_STOPPED = 2'd0,
        RUN_RUNNING = 2'd1,
        RUN_PAUSED  = 2'd2
    } t_run;

    typedef struct packed {
        t_run               status;
        logic [COUNT_W-1:0] count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_CMD_RD,
        S_CMD_WR,
        S_RESULT
    } t_fsm;

endpackage
`default_nettype wire

// ----- sv/swtb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module swtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/swtb_step.sv -----
// Update unit that applies one command or one tick to a single timer entry.
`default_nettype none
module swtb_step (
    input  wire logic [swtb_pkg::CMD_W-1:0] i_cmd,
    input  wire swtb_pkg::t_entry           i_entry,
    output swtb_pkg::t_entry                o_entry
);

    always_comb begin
        o_entry = i_entry;
        case (i_cmd)
            swtb_pkg::CMD_TICK: begin
                if (i_entry.status == swtb_pkg::RUN_RUNNING) begin
                    o_entry.count = i_entry.count + swtb_pkg::COUNT_W'(1);
                end
            end
            swtb_pkg::CMD_START: begin
                if (i_entry.status == swtb_pkg::RUN_STOPPED) begin
                    o_entry.count  = '0;
                    o_entry.status = swtb_pkg::RUN_RUNNING;
                end
            end
            swtb_pkg::CMD_STOP: begin
                o_entry.status = swtb_pkg::RUN_STOPPED;
            end
            swtb_pkg::CMD_PAUSE: begin
                if (i_entry.status == swtb_pkg::RUN_RUNNING) begin
                    o_entry.status = swtb_pkg::RUN_PAUSED;
                end
            end
            swtb_pkg::CMD_RELEASE: begin
                if (i_entry.status == swtb_pkg::RUN_PAUSED) begin
                    o_entry.status = swtb_pkg::RUN_RUNNING;
                end
            end
            default: begin
                o_entry = i_entry;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/stopwatch_timer_bank_core.sv -----
// Top level of the stopwatch timer bank: sequencer, entry memory and result register.
//
// A request is taken at a rising edge where start is high and busy is low; it
// carries a command (tick, start, stop, pause, release, read) and a timer index.
// Each request returns one result: the addressed timer's count and status after
// the command, shown for one cycle with o_done high. The receiver cannot stall,
// so nothing waits on the result side.
// All timer entries live in one RAM with a registered read port; one update unit
// serves every entry. A tick walks the whole bank through that unit, reading one
// entry and writing back the previous one each cycle, then raises o_done. Any
// other command reads, updates and writes one entry in the states S_CMD_RD and
// S_CMD_WR, then raises o_done. A non-tick command whose index lies beyond the
// bank touches no entry, goes straight to o_done and returns a zero count with
// stopped status. A new request can be taken as soon as busy is low again.
// busy stays high from the request edge until the cycle after o_done.
// Reset clears the per-entry valid bits; an entry never written reads as
// stopped with a zero count, so no clearing pass is needed.
`default_nettype none
module stopwatch_timer_bank_core #(
    parameter int NUM_TIMERS = swtb_pkg::NUM_TIMERS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [swtb_pkg::CMD_W-1:0]       i_command,
    input  wire logic [swtb_pkg::INDEX_W-1:0]     i_timer_index,
    output logic                                  o_done,
    output logic      [swtb_pkg::COUNT_W-1:0]     o_count_value,
    output logic      [swtb_pkg::STATUS_W-1:0]    o_timer_status
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);
    localparam logic [CNT_W-1:0] PTR_END = CNT_W'(NUM_TIMERS);

    swtb_pkg::t_fsm r_state, n_state;
    logic [CNT_W-1:0]              r_ptr, n_ptr;
    logic [swtb_pkg::CMD_W-1:0]    r_cmd;
    logic [swtb_pkg::INDEX_W-1:0]  r_idx;
    logic                          r_idx_ok;
    logic [IDX_W-1:0]              r_rd_addr;
    logic                          r_wr_vld;
    logic [NUM_TIMERS-1:0]         r_valid;
    swtb_pkg::t_entry              r_res;

    logic                          accept;
    logic                          idx_ok_in;
    logic [8:0]                    idx_ext;
    logic [IDX_W-1:0]              cmd_addr;
    logic [IDX_W-1:0]              ptr_addr;
    logic                          ram_re;
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_raddr;
    logic [IDX_W-1:0]              ram_waddr;
    logic [swtb_pkg::ENTRY_W-1:0]  ram_q;
    swtb_pkg::t_entry              rd_entry;
    swtb_pkg::t_entry              upd_entry;
    logic                          capture;

    assign busy      = (r_state != swtb_pkg::S_IDLE);
    assign accept    = start && !busy;
    assign idx_ok_in = ({5'd0, i_timer_index} < 9'(NUM_TIMERS));
    assign idx_ext   = {5'd0, r_idx};
    assign cmd_addr  = idx_ext[IDX_W-1:0];
    assign ptr_addr  = r_ptr[IDX_W-1:0];
    assign rd_entry  = r_valid[r_rd_addr] ? swtb_pkg::t_entry'(ram_q) : '0;

    swtb_ram #(
        .WIDTH (swtb_pkg::ENTRY_W),
        .DEPTH (NUM_TIMERS),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (upd_entry),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    swtb_step u_step (
        .i_cmd   (r_cmd),
        .i_entry (rd_entry),
        .o_entry (upd_entry)
    );

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        case (r_state)
            swtb_pkg::S_IDLE: begin
                n_ptr = '0;
                if (accept) begin
                    if (i_command == swtb_pkg::CMD_TICK) begin
                        n_state = swtb_pkg::S_WALK;
                    end else if (idx_ok_in) begin
                        n_state = swtb_pkg::S_CMD_RD;
                    end else begin
                        n_state = swtb_pkg::S_RESULT;
                    end
                end
            end
            swtb_pkg::S_WALK: begin
                if (r_ptr == PTR_END) begin
                    n_state = swtb_pkg::S_RESULT;
                end else begin
                    n_ptr = r_ptr + CNT_W'(1);
                end
            end
            swtb_pkg::S_CMD_RD: begin
                n_state = swtb_pkg::S_CMD_WR;
            end
            swtb_pkg::S_CMD_WR: begin
                n_state = swtb_pkg::S_RESULT;
            end
            swtb_pkg::S_RESULT: begin
                n_state = swtb_pkg::S_IDLE;
            end
            default: begin
                n_state = swtb_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = ptr_addr;
        ram_waddr = r_rd_addr;
        capture   = 1'b0;
        case (r_state)
            swtb_pkg::S_WALK: begin
                ram_re    = (r_ptr != PTR_END);
                ram_raddr = ptr_addr;
                ram_we    = r_wr_vld;
                ram_waddr = r_rd_addr;
                capture   = r_wr_vld && r_idx_ok && (r_rd_addr == cmd_addr);
            end
            swtb_pkg::S_CMD_RD: begin
                ram_re    = 1'b1;
                ram_raddr = cmd_addr;
            end
            swtb_pkg::S_CMD_WR: begin
                ram_we    = 1'b1;
                ram_waddr = cmd_addr;
                capture   = 1'b1;
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= swtb_pkg::S_IDLE;
            r_ptr    <= '0;
            r_wr_vld <= 1'b0;
            r_valid  <= '0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_wr_vld <= (r_state == swtb_pkg::S_WALK) && ram_re;
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_command;
            r_idx    <= i_timer_index;
            r_idx_ok <= idx_ok_in;
            r_res    <= '0;
        end else if (capture) begin
            r_res <= upd_entry;
        end
        if (ram_re) begin
            r_rd_addr <= ram_raddr;
        end
    end

    assign o_done         = (r_state == swtb_pkg::S_RESULT);
    assign o_count_value  = r_res.count;
    assign o_timer_status = r_res.status;

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("Result strobe outside a request.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Request accepted but block not busy.");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("Block still busy after the result.");

    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ({1'b0, ram_waddr} < (IDX_W + 1)'(NUM_TIMERS)))
        else $error("Entry write beyond the bank.");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_timer_status != 2'd3))
        else $error("Result carries an undefined status.");

endmodule
`default_nettype wire

// ----- test/stopwatch_timer_bank_core_test.sv -----
// Self-checking testbench for the stopwatch timer bank: directed table, then random requests.
`default_nettype none
module stopwatch_timer_bank_core_test;
    import swtb_pkg::*;

    localparam int BANK_SIZE    = NUM_TIMERS_DEF;
    localparam int DIRECTED_LEN = 24;
    localparam int RANDOM_ITEMS = 900;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int PRINT_LIMIT  = 50;

    localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [INDEX_W-1:0] idx;
        logic               typed;
        logic [COUNT_W-1:0] cnt;
        t_run               st;
    } t_stim_row;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                start         = 1'b0;
    logic [CMD_W-1:0]    i_command     = CMD_TICK;
    logic [INDEX_W-1:0]  i_timer_index = '0;
    logic                busy;
    logic                o_done;
    logic [COUNT_W-1:0]  o_count_value;
    logic [STATUS_W-1:0] o_timer_status;

    t_run               timer_state [BANK_SIZE];
    logic [COUNT_W-1:0] timer_count [BANK_SIZE];
    t_entry             pending_results [$];
    t_entry             oldest_result;
    t_stim_row          directed_rows [DIRECTED_LEN];
    int                 mismatch_count = 0;

    stopwatch_timer_bank_core #(
        .NUM_TIMERS(BANK_SIZE)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_timer_index  (i_timer_index),
        .o_done         (o_done),
        .o_count_value  (o_count_value),
        .o_timer_status (o_timer_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_entry apply_command(input logic [CMD_W-1:0] cmd,
                                             input logic [INDEX_W-1:0] idx);
        t_entry outcome;
        logic   in_bank;
        in_bank = int'(idx) < BANK_SIZE;
        if (cmd == CMD_TICK) begin
            for (int t = 0; t < BANK_SIZE; t++) begin
                if (timer_state[t] == RUN_RUNNING) begin
                    timer_count[t] = timer_count[t] + 1'b1;
                end
            end
        end else if (in_bank) begin
            case (cmd)
                CMD_START: begin
                    if (timer_state[idx] == RUN_STOPPED) begin
                        timer_count[idx] = '0;
                        timer_state[idx] = RUN_RUNNING;
                    end
                end
                CMD_STOP: begin
                    timer_state[idx] = RUN_STOPPED;
                end
                CMD_PAUSE: begin
                    if (timer_state[idx] == RUN_RUNNING) begin
                        timer_state[idx] = RUN_PAUSED;
                    end
                end
                CMD_RELEASE: begin
                    if (timer_state[idx] == RUN_PAUSED) begin
                        timer_state[idx] = RUN_RUNNING;
                    end
                end
                default: begin
                end
            endcase
        end
        outcome.count  = in_bank ? timer_count[idx] : '0;
        outcome.status = in_bank ? timer_state[idx] : RUN_STOPPED;
        return outcome;
    endfunction

    task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] expected_value,
                                   input logic [COUNT_W-1:0] got_value);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("Mismatch in %s at %0t: expected %0d, got %0d",
                     what, $realtime, expected_value, got_value);
        end
        mismatch_count++;
    endtask

    task automatic send_request(input t_stim_row row);
        t_entry predicted;
        i_command     <= row.cmd;
        i_timer_index <= row.idx;
        start         <= 1'b1;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        predicted = apply_command(row.cmd, row.idx);
        if (row.typed) begin
            predicted.count  = row.cnt;
            predicted.status = row.st;
        end
        pending_results.push_back(predicted);
    endtask

    task automatic idle_after(input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic int pick_gap(input logic quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic t_stim_row random_row();
        t_stim_row row;
        int        roll;
        roll      = $urandom_range(0, 99);
        row       = '0;
        row.typed = 1'b0;
        row.st    = RUN_STOPPED;
        if (roll < 25) begin
            row.cmd = CMD_TICK;
        end else if (roll < 42) begin
            row.cmd = CMD_START;
        end else if (roll < 52) begin
            row.cmd = CMD_STOP;
        end else if (roll < 66) begin
            row.cmd = CMD_PAUSE;
        end else if (roll < 80) begin
            row.cmd = CMD_RELEASE;
        end else if (roll < 94) begin
            row.cmd = CMD_READ;
        end else begin
            row.cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE6 : CMD_SPARE7;
        end
        if ($urandom_range(0, 3) < 3) begin
            row.idx = INDEX_W'($urandom_range(0, 3));
        end else begin
            row.idx = INDEX_W'($urandom_range(0, 15));
        end
        return row;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result count", '0, o_count_value);
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_count_value !== oldest_result.count) begin
                    report_mismatch("count_value", oldest_result.count, o_count_value);
                end
                if (o_timer_status !== oldest_result.status) begin
                    report_mismatch("timer_status", COUNT_W'(oldest_result.status),
                                    COUNT_W'(o_timer_status));
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int   drain_cycles;
        logic quiet;
        foreach (timer_state[t]) begin
            timer_state[t] = RUN_STOPPED;
            timer_count[t] = '0;
        end
        directed_rows = '{
            '{CMD_READ,    4'd0,  1'b1, 32'd0, RUN_STOPPED},
            '{CMD_READ,    4'd15, 1'b1, 32'd0, RUN_STOPPED},
            '{CMD_TICK,    4'd0,  1'b1, 32'd0, RUN_STOPPED},
            '{CMD_START,   4'd0,  1'b1, 32'd0, RUN_RUNNING},
            '{CMD_TICK,    4'd0,  1'b0, 32'd0, RUN_STOPPED},
            '{CMD_TICK,    4'd15, 1'b0, 32'd0, RUN_STOPPED},
            '{CMD_START,   4'd0,  1'b0, 32'd0, RUN_STOPPED},
            '{CMD_PAUSE,   4'd0,  1'b0, 32'd0, RUN_STOPPED},
            '{CMD_TICK,    4'd0,  1'b0, 32'd0, RUN_STOPPED},
            '{CMD_PAUSE,   4'd0,  1'b0, 32'd0, RUN_STOPPED},
            '{CMD_RELEASE, 4'd0,  1'b0, 32'd0, RUN_STOPPED},
            '{CMD_RELEASE, 4'd0,  1'b0, 32'd0, RUN_STOPPED},
            '{CMD_START,   4'd15, 1'b1, 32'd0, RUN_RUNNING},
            '{CMD_TICK,    4'd3,  1'b0, 32'd0, RUN_STOPPED},
            '{CMD_STOP,    4'd0,  1'b0, 32'd0, RUN_STOPPED},
            '{CMD_STOP,    4'd0,  1'b0, 32'd0, RUN_STOPPED},
            '{CMD_PAUSE,   4'd5,  1'b1, 32'd0, RUN_STOPPED},
            '{CMD_RELEASE, 4'd5,  1'b1, 32'd0, RUN_STOPPED},
            '{CMD_SPARE6,  4'd15, 1'b0, 32'd0, RUN_STOPPED},
            '{CMD_SPARE7,  4'd15, 1'b0, 32'd0, RUN_STOPPED},
            '{CMD_START,   4'd0,  1'b1, 32'd0, RUN_RUNNING},
            '{CMD_STOP,    4'd15, 1'b0, 32'd0, RUN_STOPPED},
            '{CMD_PAUSE,   4'd15, 1'b0, 32'd0, RUN_STOPPED},
            '{CMD_TICK,    4'd7,  1'b0, 32'd0, RUN_STOPPED}
        };
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[r]) begin
            send_request(directed_rows[r]);
            idle_after(pick_gap(1'b0));
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = ((n / 100) % 4) == 2;
            if (n == RANDOM_ITEMS / 2) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (pending_results.size() != 0) begin
                    @(posedge i_clk);
                end
            end
            send_request(random_row());
            idle_after(pick_gap(quiet));
        end
        start <= 1'b0;
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        if (pending_results.size() != 0) begin
            report_mismatch("results still outstanding", COUNT_W'(pending_results.size()), '0);
        end
        repeat (BANK_SIZE + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
sv/swtb_pkg.sv
sv/swtb_ram.sv
sv/swtb_step.sv
sv/stopwatch_timer_bank_core.sv
test/stopwatch_timer_bank_core_test.sv
